FILE: sv/block_bitmap_allocator_unit_assert.svh
// Assertion macros for the block allocator.
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bba_pkg.sv
package bba_pkg;

    localparam int NUM_BLOCKS = 2048;
    localparam int MAP_WORDS  = (NUM_BLOCKS + 31) / 32;
    localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int TAIL_BITS  = NUM_BLOCKS % 32;
    localparam int BLK_W      = 13;

    typedef logic [BLK_W-1:0]   t_blk;
    typedef logic [WORD_AW-1:0] t_word_addr;
    typedef logic [31:0]        t_map_word;

endpackage

FILE: sv/bba_ram.sv
module bba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/block_bitmap_allocator_unit.sv
// First-fit block allocator over a used-map of NUM_BLOCKS bits (one per data
// block), kept in a 32-bit-wide RAM of MAP_WORDS words. After reset a clearing
// pass writes every map word to zero, one word a cycle; s_tready stays low
// meanwhile, config writes still land. Each input beat gives exactly one
// output beat. Allocate (s_tuser = 0) scans the map one word per cycle from
// word 0 and grants first_data_block + index of the lowest free bit, after
// reading 1 to MAP_WORDS words. Free (s_tuser = 1) is one read-modify-write.
// A free below first_data_block or past the map returns ok = 0 and leaves the
// map alone. Map indices whose block number would exceed 8191 are never
// granted. The single RAM read port sets the scan rate; one item is in flight
// at a time. first_data_block is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while idle, which the block itself does not enforce.
module block_bitmap_allocator_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: first_data_block
    input  logic                 i_cfg_we,
    input  bba_pkg::t_blk        i_cfg_wdata,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [12:0] block_number, [15:13] zero
    input  logic                 s_tuser,   // [0] action
    // response stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [12:0] granted_block, [15:13] zero
    output logic                 m_tuser    // [0] ok
);

    import bba_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_FREE = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam t_word_addr LAST_WORD = WORD_AW'(MAP_WORDS - 1);
    localparam t_blk       BLK_MAX   = {BLK_W{1'b1}};

    logic [2:0]  r_state, n_state;
    t_word_addr  r_word, n_word;
    logic [4:0]  r_bit, n_bit;
    t_blk        r_first;
    t_blk        r_res_blk, n_res_blk;
    logic        r_res_ok, n_res_ok;
    logic        r_out_valid;
    t_blk        r_out_blk;
    logic        r_out_ok;

    logic        ram_we;
    t_word_addr  ram_waddr, ram_raddr;
    t_map_word   ram_wdata, ram_rdata;

    logic        in_fire;
    logic        out_load;
    t_blk        req_blk;

    // free decode
    t_blk        free_diff;
    logic        free_ok;

    // scan decode
    t_blk        lim;           // largest index whose block number fits
    logic [7:0]  lim_word;
    logic [7:0]  cur_word;
    t_map_word   valid_mask;
    t_map_word   avail;
    logic        hit;
    logic [4:0]  hit_bit;
    logic        scan_end;

    bba_ram #(
        .WIDTH  (32),
        .DEPTH  (MAP_WORDS),
        .ADDR_W (WORD_AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_tready = (r_state == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign req_blk  = s_tdata[BLK_W-1:0];

    assign free_diff = req_blk - r_first;
    assign free_ok   = (req_blk >= r_first) && (free_diff < BLK_W'(NUM_BLOCKS));

    assign lim      = BLK_MAX - r_first;
    assign lim_word = lim[12:5];
    assign cur_word = 8'(r_word);

    // bits of the current word that may be handed out
    always_comb begin
        for (int b = 0; b < 32; b++) begin
            valid_mask[b] = (cur_word < lim_word) ||
                            ((cur_word == lim_word) && (5'(b) <= lim[4:0]));
            if (TAIL_BITS != 0 && r_word == LAST_WORD && b >= TAIL_BITS) begin
                valid_mask[b] = 1'b0;
            end
        end
    end

    assign avail    = ~ram_rdata & valid_mask;
    assign hit      = |avail;
    assign scan_end = (r_word == LAST_WORD) || (cur_word >= lim_word);

    // lowest free bit
    always_comb begin
        hit_bit = 5'd0;
        for (int b = 31; b >= 0; b--) begin
            if (avail[b]) begin
                hit_bit = 5'(b);
            end
        end
    end

    // map RAM ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = '0;
        ram_raddr = '0;
        case (r_state)
            ST_CLR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                if (s_tuser == ACT_FREE) begin
                    ram_raddr = free_diff[5 +: WORD_AW];
                end
            end
            ST_SCAN: begin
                ram_raddr = r_word + 1'b1;   // speculative next word
                if (hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (32'd1 << hit_bit);
                end
            end
            ST_FREE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(32'd1 << r_bit);
            end
            default: begin
            end
        endcase
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_tready);

    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_bit     = r_bit;
        n_res_blk = r_res_blk;
        n_res_ok  = r_res_ok;
        case (r_state)
            ST_CLR: begin
                n_word = r_word + 1'b1;
                if (r_word == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == ACT_ALLOC) begin
                        n_word  = '0;
                        n_state = ST_SCAN;
                    end else if (free_ok) begin
                        n_word  = free_diff[5 +: WORD_AW];
                        n_bit   = free_diff[4:0];
                        n_state = ST_FREE;
                    end else begin
                        n_res_blk = '0;
                        n_res_ok  = 1'b0;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_res_blk = r_first + BLK_W'({r_word, hit_bit});
                    n_res_ok  = 1'b1;
                    n_state   = ST_DONE;
                end else if (scan_end) begin
                    n_res_blk = '0;
                    n_res_ok  = 1'b0;
                    n_state   = ST_DONE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            ST_FREE: begin
                n_res_blk = '0;
                n_res_ok  = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_word      <= '0;
            r_first     <= BLK_W'(16);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            if (i_cfg_we) begin
                r_first <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit     <= n_bit;
        r_res_blk <= n_res_blk;
        r_res_ok  <= n_res_ok;
        if (out_load) begin
            r_out_blk <= r_res_blk;
            r_out_ok  <= r_res_ok;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = 16'(r_out_blk);
    assign m_tuser  = r_out_ok;

`include "block_bitmap_allocator_unit_assert.svh"

    `BBA_ASSERT_NOW(a_no_accept_in_clear, r_state == ST_CLR, !s_tready, "beat accepted during map clear")
    `BBA_ASSERT_NOW(a_fail_zero_block, m_tvalid && !m_tuser, m_tdata == 16'd0, "failed response with nonzero block")
    `BBA_ASSERT_NEXT(a_accept_moves_on, in_fire, r_state == ST_SCAN || r_state == ST_FREE || r_state == ST_DONE, "accepted beat left FSM idle")
    `BBA_ASSERT_NOW(a_write_states, ram_we, r_state == ST_CLR || r_state == ST_SCAN || r_state == ST_FREE, "map write outside clear or update")

endmodule

FILE: verif/tb_block_bitmap_allocator_unit.sv
module tb_block_bitmap_allocator_unit;

    import bba_pkg::*;

    // Request kinds as carried on s_tuser.
    typedef enum bit {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } act_e;

    typedef struct packed {
        act_e act;
        t_blk blk;
        bit   drain;    // hold this beat back until every answer is in
    } req_t;

    typedef struct packed {
        t_blk granted;
        bit   ok;
    } grant_t;

    localparam int BLK_MAX    = (1 << BLK_W) - 1;
    localparam int PAD_W      = 16 - BLK_W;
    localparam int QUIET_MAX  = 4000;              // cycles with no beat either side
    localparam int TAIL_WAIT  = 2 * MAP_WORDS + 16; // longest scan plus margin

    // DUT inputs, all at known values from time zero.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    t_blk        i_cfg_wdata = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // [12:0] block_number, [15:13] zero
    logic        s_tuser     = 1'b0; // [0] action
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;            // [12:0] granted_block, [15:13] zero
    logic        m_tuser;            // [0] ok

    // Request beats waiting to be driven, answers waiting to be seen.
    req_t        pend_q[$];
    grant_t      grant_q[$];

    // Shadow of the allocator: used-map and the data start register.
    bit [NUM_BLOCKS-1:0] used_bits;
    t_blk        first_blk;

    int unsigned items_queued = 0;
    int unsigned beats_out    = 0;
    int unsigned fails        = 0;
    int          idle_pct     = 0;
    int          stall_pct    = 0;

    block_bitmap_allocator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // First-fit grant / free against the shadow map. Indices whose absolute
    // number would not fit in 13 bits end the scan; nothing past them is granted.
    function automatic void predict_grant(input act_e act, input t_blk blk,
                                          output t_blk granted, output bit ok);
        int idx;
        granted = '0;
        ok      = 1'b0;
        if (act == ACT_ALLOC) begin
            for (idx = 0; idx < NUM_BLOCKS; idx++) begin
                if (int'(first_blk) + idx > BLK_MAX)
                    break;
                if (!used_bits[idx]) begin
                    used_bits[idx] = 1'b1;
                    granted        = t_blk'(int'(first_blk) + idx);
                    ok             = 1'b1;
                    break;
                end
            end
        end else if (blk >= first_blk) begin
            idx = int'(blk) - int'(first_blk);
            // freeing a block that is already free still answers ok
            if (idx < NUM_BLOCKS) begin
                used_bits[idx] = 1'b0;
                ok             = 1'b1;
            end
        end
    endfunction

    // Driver: at each edge, record an accepted beat and present the next one.
    // tvalid only drops after a beat is taken, so it never toggles in a step.
    always @(posedge i_clk) begin : driver
        bit     took;
        req_t   nxt;
        grant_t want;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            took = s_tvalid && s_tready;
            if (took) begin
                predict_grant(act_e'(s_tuser), s_tdata[BLK_W-1:0], want.granted, want.ok);
                grant_q.push_back(want);
            end
            if (!s_tvalid || took) begin
                if (pend_q.size() != 0 && !(pend_q[0].drain && grant_q.size() != 0)
                    && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.act;
                    s_tdata  <= {{PAD_W{1'b0}}, nxt.blk};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: each answer beat against the oldest expected grant.
    always @(posedge i_clk) begin : monitor
        grant_t want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (grant_q.size() == 0) begin
                    fails++;
                    $display("%0t: answer beat with nothing expected: block %0d ok %0b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = grant_q.pop_front();
                    if (m_tdata !== {{PAD_W{1'b0}}, want.granted} || m_tuser !== want.ok) begin
                        fails++;
                        $display("%0t: mismatch: expected block %0d ok %0b, got block %0d ok %0b",
                                 $time, want.granted, want.ok, m_tdata, m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: too long with no beat on either side means a hang.
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n) begin
            quiet = 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("%0t: no beat for %0d cycles", $time, quiet);
                $display("block_bitmap_allocator_unit verification failed");
                $finish;
            end
        end
    end

    task automatic push_req(input act_e act, input t_blk blk, input bit drain);
        req_t r;
        r.act   = act;
        r.blk   = blk;
        r.drain = drain;
        pend_q.push_back(r);
        items_queued++;
    endtask

    // Wait for every queued beat to be answered, then optionally move the
    // data start and set the pacing of both sides.
    task automatic begin_phase(input bit do_cfg, input t_blk cfg, input int idle,
                               input int stall);
        while (beats_out < items_queued)
            @(posedge i_clk);
        if (do_cfg) begin
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= cfg;
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            first_blk    = cfg;
        end
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    // Mostly in-range frees; the rest below the data start, past the map,
    // or anywhere in the 13-bit space.
    function automatic t_blk free_target();
        int r;
        int lo;
        r  = $urandom_range(0, 99);
        lo = int'(first_blk) + NUM_BLOCKS;
        if (r < 80)
            return t_blk'(int'(first_blk) + $urandom_range(0, NUM_BLOCKS - 1));
        if (r < 88 && first_blk != 0)
            return t_blk'($urandom_range(0, int'(first_blk) - 1));
        if (r < 95 && lo <= BLK_MAX)
            return t_blk'($urandom_range(lo, BLK_MAX));
        return t_blk'($urandom_range(0, BLK_MAX));
    endfunction

    // Random mix; the first beat of a phase, and a rare random one, waits for the pipe to drain.
    task automatic random_phase(input int n, input int free_pct);
        int i;
        bit hold;
        for (i = 0; i < n; i++) begin
            hold = (i == 0) || ($urandom_range(0, 99) == 0);
            if ($urandom_range(0, 99) < free_pct)
                push_req(ACT_FREE, free_target(), hold);
            else
                push_req(ACT_ALLOC, t_blk'($urandom), hold);  // block number is noise
        end
    endtask

    initial begin : stimulus
        int i;
        used_bits = '0;
        first_blk = t_blk'(16);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, data start at its reset value of 16.
        push_req(ACT_ALLOC, '0, 1'b0);                // 16
        push_req(ACT_ALLOC, t_blk'(BLK_MAX), 1'b0);   // 17, block field ignored
        push_req(ACT_FREE, t_blk'(17), 1'b0);
        push_req(ACT_ALLOC, '0, 1'b0);                // 17 again
        push_req(ACT_FREE, t_blk'(16 + NUM_BLOCKS - 1), 1'b0);  // last map entry
        push_req(ACT_FREE, t_blk'(16 + NUM_BLOCKS), 1'b0);      // one past the map
        push_req(ACT_FREE, t_blk'(15), 1'b0);         // just below data start
        push_req(ACT_FREE, '0, 1'b0);
        push_req(ACT_FREE, t_blk'(BLK_MAX), 1'b0);
        push_req(ACT_FREE, t_blk'(16), 1'b0);
        push_req(ACT_FREE, t_blk'(16), 1'b0);         // already free
        push_req(ACT_ALLOC, t_blk'(BLK_MAX), 1'b0);

        // Data start zero: a grant of block 0 is a success.
        begin_phase(1'b1, '0, 0, 0);
        push_req(ACT_ALLOC, '0, 1'b0);
        push_req(ACT_FREE, '0, 1'b0);
        push_req(ACT_ALLOC, '0, 1'b0);                // block 0, ok

        // Data start at the top: only index 0 fits in 13 bits.
        begin_phase(1'b1, t_blk'(BLK_MAX), 0, 0);
        push_req(ACT_ALLOC, '0, 1'b0);                // index 0 taken, index 1 too wide
        push_req(ACT_FREE, t_blk'(BLK_MAX), 1'b0);
        push_req(ACT_ALLOC, '0, 1'b0);
        push_req(ACT_ALLOC, '0, 1'b0);
        push_req(ACT_FREE, t_blk'(BLK_MAX - 1), 1'b0);

        // Whole map exactly reaches block 8191.
        begin_phase(1'b1, t_blk'(BLK_MAX + 1 - NUM_BLOCKS), 0, 0);
        push_req(ACT_FREE, t_blk'(BLK_MAX), 1'b0);
        push_req(ACT_ALLOC, '0, 1'b0);

        // Data start near the top: indices 0 to 69 fit, spread over three
        // words. Fill them, then keep asking so the full answer shows up.
        begin_phase(1'b1, t_blk'(BLK_MAX - 69), 0, 0);
        for (i = 0; i < 72; i++)
            push_req(ACT_ALLOC, t_blk'($urandom), 1'b0);

        // Random phases over data starts and pacing.
        begin_phase(1'b1, t_blk'(16), 0, 0);
        random_phase(250, 55);
        begin_phase(1'b1, t_blk'(1), 67, 0);
        random_phase(400, 50);
        begin_phase(1'b1, t_blk'(4096), 0, 67);
        random_phase(400, 45);
        begin_phase(1'b1, t_blk'($urandom_range(0, BLK_MAX)), 38, 38);
        random_phase(400, 50);
        begin_phase(1'b1, '0, 38, 38);
        random_phase(250, 50);
        begin_phase(1'b1, t_blk'(BLK_MAX), 0, 0);
        random_phase(50, 50);

        // Drain, then give any stray beat time to show.
        begin_phase(1'b0, '0, 0, 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (grant_q.size() != 0) begin
            fails++;
            $display("%0t: %0d expected answers never came", $time, grant_q.size());
        end
        if (fails == 0)
            $display("block_bitmap_allocator_unit verification clean");
        else
            $display("block_bitmap_allocator_unit verification failed");
        $finish;
    end

endmodule

FILE: block_bitmap_allocator_unit.f
+incdir+sv
sv/bba_pkg.sv
sv/bba_ram.sv
sv/block_bitmap_allocator_unit.sv
verif/tb_block_bitmap_allocator_unit.sv
